### hw/rtl/qte_pkg.sv
package qte_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int GUARD_BITS = 8;
    localparam int UBITS      = 32;
    localparam int SV_SHIFT   = FRAC_BITS - GUARD_BITS;

    localparam int VAL_W  = 32;
    localparam int TIME_W = 24;
    localparam int IDX_W  = 3;
    localparam int ACC_W  = 64;
    localparam int SH_W   = 6;

    localparam int MUL_LAT   = 4;
    localparam int DIV_LAT   = ACC_W + 1;
    localparam int COEF_WAIT = 4 * MUL_LAT + 4;

    localparam logic [TIME_W-1:0] DUR_RESET = TIME_W'(1) << FRAC_BITS;

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [ACC_W-1:0] mag_t;

    localparam mag_t LIM_MAG = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t LIM     = LIM_MAG;
    localparam logic signed [ACC_W:0]   LIM_W = {1'b0, LIM_MAG};
    localparam logic signed [ACC_W+7:0] LIM_K = {8'b0, LIM_MAG};
    localparam mag_t NEG_MAG = mag_t'(1) << (VAL_W - 1);
    localparam mag_t POS_MAG = NEG_MAG - mag_t'(1);

    typedef enum logic [IDX_W-1:0] {
        REG_START_POS = 3'd0,
        REG_START_VEL = 3'd1,
        REG_START_ACC = 3'd2,
        REG_END_POS   = 3'd3,
        REG_END_VEL   = 3'd4,
        REG_END_ACC   = 3'd5,
        REG_DURATION  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        acc_t val;
        logic ov;
    } sat_t;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic             ov;
    } nar_t;

    function automatic mag_t mag(acc_t x);
        return x[ACC_W-1] ? mag_t'(-x) : mag_t'(x);
    endfunction

    // symmetric saturating add
    function automatic sat_t sadd(acc_t a, acc_t b);
        logic signed [ACC_W:0] s;
        sat_t r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s > LIM_W) begin
            r.val = LIM;
            r.ov  = 1'b1;
        end else if (s < -LIM_W) begin
            r.val = -LIM;
            r.ov  = 1'b1;
        end else begin
            r.val = acc_t'(s);
            r.ov  = 1'b0;
        end
        return r;
    endfunction

    // product with a small signed constant, saturated
    function automatic sat_t mulk(acc_t a, logic signed [7:0] k);
        logic signed [ACC_W+7:0] p;
        sat_t r;
        p = (ACC_W+8)'(a) * (ACC_W+8)'(k);
        if (p > LIM_K) begin
            r.val = LIM;
            r.ov  = 1'b1;
        end else if (p < -LIM_K) begin
            r.val = -LIM;
            r.ov  = 1'b1;
        end else begin
            r.val = acc_t'(p);
            r.ov  = 1'b0;
        end
        return r;
    endfunction

    // round off the guard bits and saturate to the output width
    function automatic nar_t narrow(acc_t x);
        mag_t m;
        nar_t r;
        m = (mag(x) + (mag_t'(1) << (GUARD_BITS - 1))) >> GUARD_BITS;
        r.ov = 1'b0;
        if (x[ACC_W-1]) begin
            if (m > NEG_MAG) begin
                r.ov = 1'b1;
                m = NEG_MAG;
            end
            r.val = VAL_W'(-m);
        end else begin
            if (m > POS_MAG) begin
                r.ov = 1'b1;
                m = POS_MAG;
            end
            r.val = VAL_W'(m);
        end
        return r;
    endfunction

    function automatic acc_t raw_in(logic [VAL_W-1:0] v);
        return acc_t'(signed'(v));
    endfunction

    function automatic acc_t scale_in(logic [VAL_W-1:0] v);
        return acc_t'(signed'(v)) <<< GUARD_BITS;
    endfunction

endpackage

### hw/rtl/qte_mulq.sv
module qte_mulq (
    input  logic                           aclk,
    input  logic                           en,
    input  qte_pkg::acc_t                  a,
    input  qte_pkg::acc_t                  b,
    input  qte_pkg::acc_t                  c,
    input  logic [qte_pkg::SH_W-1:0]       sh,
    input  logic                           ov_in,
    output qte_pkg::acc_t                  p,
    output logic                           ov_out
);
    import qte_pkg::*;

    localparam int HW = ACC_W / 2;
    localparam int PW = 2 * ACC_W;

    mag_t ma_reg, mb_reg;
    logic neg1_reg, neg2_reg;
    acc_t c1_reg, c2_reg, c3_reg;
    logic ov1_reg, ov2_reg, ov3_reg;
    mag_t p00_reg, p01_reg, p10_reg, p11_reg;
    acc_t v3_reg;
    acc_t p_reg;
    logic ov_reg;

    logic [PW-1:0] full, rnd, shf;
    mag_t m3;
    logic sat3;
    acc_t v3_next;
    sat_t s4;

    always_comb begin
        full = (PW'(p11_reg) << ACC_W) + (PW'(p01_reg) << HW)
             + (PW'(p10_reg) << HW) + PW'(p00_reg);
        rnd  = (sh == '0) ? '0 : (PW'(1) << (sh - SH_W'(1)));
        shf  = (full + rnd) >> sh;
        sat3 = shf > PW'(LIM_MAG);
        m3   = sat3 ? LIM_MAG : shf[ACC_W-1:0];
        v3_next = neg2_reg ? -acc_t'(m3) : acc_t'(m3);
        s4   = sadd(v3_reg, c3_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg   <= mag(a);
            mb_reg   <= mag(b);
            neg1_reg <= a[ACC_W-1] ^ b[ACC_W-1];
            c1_reg   <= c;
            ov1_reg  <= ov_in;

            p00_reg  <= mag_t'(ma_reg[HW-1:0]) * mag_t'(mb_reg[HW-1:0]);
            p01_reg  <= mag_t'(ma_reg[HW-1:0]) * mag_t'(mb_reg[ACC_W-1:HW]);
            p10_reg  <= mag_t'(ma_reg[ACC_W-1:HW]) * mag_t'(mb_reg[HW-1:0]);
            p11_reg  <= mag_t'(ma_reg[ACC_W-1:HW]) * mag_t'(mb_reg[ACC_W-1:HW]);
            neg2_reg <= neg1_reg;
            c2_reg   <= c1_reg;
            ov2_reg  <= ov1_reg;

            v3_reg   <= v3_next;
            c3_reg   <= c2_reg;
            ov3_reg  <= ov2_reg | sat3;

            p_reg    <= s4.val;
            ov_reg   <= ov3_reg | s4.ov;
        end
    end

    assign p      = p_reg;
    assign ov_out = ov_reg;

endmodule

### hw/rtl/qte_divt.sv
module qte_divt (
    input  logic                           aclk,
    input  logic                           en,
    input  qte_pkg::acc_t                  x,
    input  logic [qte_pkg::SH_W-1:0]       sh,
    input  logic [qte_pkg::TIME_W-1:0]     td,
    input  logic                           ov_in,
    output qte_pkg::acc_t                  y,
    output logic                           ov_out
);
    import qte_pkg::*;

    localparam int QB = ACC_W - 1;
    localparam int NW = ACC_W + 32;

    logic [TIME_W-1:0] rem_reg [0:QB];
    logic [QB-1:0]     low_reg [0:QB];
    logic [QB-1:0]     q_reg   [0:QB];
    logic              neg_reg [0:QB];
    logic              sat_reg [0:QB];
    logic              ov_reg  [0:QB];
    acc_t              y_reg;
    logic              yov_reg;

    logic [NW-1:0]    n0;
    logic [NW-QB-1:0] hi0;
    logic             sat0;
    logic [TIME_W:0]  trial [1:QB];
    logic             ge    [1:QB];
    mag_t             qm;

    always_comb begin
        n0   = (NW'(mag(x)) << sh) + NW'(td >> 1);
        hi0  = n0[NW-1:QB];
        sat0 = hi0 >= (NW-QB)'(td);
        for (int k = 1; k <= QB; k++) begin
            trial[k] = {rem_reg[k-1], low_reg[k-1][QB-1]};
            ge[k]    = trial[k] >= {1'b0, td};
        end
        qm = sat_reg[QB] ? LIM_MAG : {1'b0, q_reg[QB]};
    end

    // one quotient bit per stage, remainder stays below td
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= sat0 ? '0 : TIME_W'(hi0);
            low_reg[0] <= n0[QB-1:0];
            q_reg[0]   <= '0;
            neg_reg[0] <= x[ACC_W-1];
            sat_reg[0] <= sat0;
            ov_reg[0]  <= ov_in;
            for (int k = 1; k <= QB; k++) begin
                rem_reg[k] <= ge[k] ? TIME_W'(trial[k] - {1'b0, td}) : TIME_W'(trial[k]);
                low_reg[k] <= {low_reg[k-1][QB-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][QB-2:0], ge[k]};
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                ov_reg[k]  <= ov_reg[k-1];
            end
            y_reg   <= neg_reg[QB] ? -acc_t'(qm) : acc_t'(qm);
            yov_reg <= ov_reg[QB] | sat_reg[QB];
        end
    end

    assign y      = y_reg;
    assign ov_out = yov_reg;

endmodule

### hw/rtl/quintic_trajectory_evaluator_unit.sv
// channel  | dir | handshake                | payload
// s_       | in  | s_tvalid / s_tready      | s_tdata: sample_time[23:0]
// m_       | out | m_tvalid / m_tready      | m_tdata: position, velocity,
//          |     |                          |   acceleration, jerk; m_tuser: overflow
// cfg_     | in  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// one sample per cycle while s_tready is high; all outputs are aligned to the jerk path,
// which runs three 65-stage divide pipelines after two Horner steps.
// after reset and after each register write s_tready is low while the wait
// counter for the coefficient unit runs down to zero.
// a held result on m_ stalls every stage of the sample pipeline at once; nothing is dropped.
module quintic_trajectory_evaluator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [qte_pkg::TIME_W-1:0]    s_tdata,   // sample_time
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [4*qte_pkg::VAL_W-1:0]   m_tdata,   // position, velocity, acceleration, jerk
    output logic [0:0]                    m_tuser,   // overflow
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [qte_pkg::IDX_W-1:0]     cfg_index,
    input  logic [qte_pkg::VAL_W-1:0]     cfg_data
);
    import qte_pkg::*;

    localparam int T_PB  = 2 * MUL_LAT;
    localparam int T_U   = DIV_LAT;
    localparam int T_S1  = T_U + MUL_LAT;
    localparam int T_S2  = T_U + 2 * MUL_LAT;
    localparam int T_S3  = T_U + 3 * MUL_LAT;
    localparam int T_S4  = T_U + 4 * MUL_LAT;
    localparam int T_POS = T_U + 5 * MUL_LAT;
    localparam int T_VB  = MUL_LAT;
    localparam int T_VEL = T_S4 + DIV_LAT;
    localparam int T_ACC = T_S3 + 2 * DIV_LAT;
    localparam int T_END = T_S2 + 3 * DIV_LAT;
    localparam int CW    = $clog2(COEF_WAIT + 1);

    localparam logic [SH_W-1:0] SH_SV = SH_W'(SV_SHIFT);
    localparam logic [SH_W-1:0] SH_F  = SH_W'(FRAC_BITS);
    localparam logic [SH_W-1:0] SH_F1 = SH_W'(FRAC_BITS + 1);
    localparam logic [SH_W-1:0] SH_FM = SH_W'(FRAC_BITS - 1);
    localparam logic [SH_W-1:0] SH_U  = SH_W'(UBITS);
    localparam logic [SH_W-1:0] SH_U1 = SH_W'(UBITS + 1);

    // ---------------- registers ----------------
    logic [VAL_W-1:0]  start_pos_reg, start_vel_reg, start_acc_reg;
    logic [VAL_W-1:0]  end_pos_reg, end_vel_reg, end_acc_reg;
    logic [TIME_W-1:0] duration_reg;
    logic [CW-1:0]     wait_cnt_reg;
    logic              cfg_fire, busy, en;
    logic [TIME_W-1:0] td;
    acc_t              t_dur;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign busy      = wait_cnt_reg != '0;
    assign td        = (duration_reg == '0) ? TIME_W'(1) : duration_reg;
    assign t_dur     = acc_t'(td);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pos_reg <= '0;
            start_vel_reg <= '0;
            start_acc_reg <= '0;
            end_pos_reg   <= '0;
            end_vel_reg   <= '0;
            end_acc_reg   <= '0;
            duration_reg  <= DUR_RESET;
            wait_cnt_reg  <= CW'(COEF_WAIT);
        end else begin
            if (cfg_fire) begin
                wait_cnt_reg <= CW'(COEF_WAIT);
                unique case (reg_idx_t'(cfg_index))
                    REG_START_POS: start_pos_reg <= cfg_data;
                    REG_START_VEL: start_vel_reg <= cfg_data;
                    REG_START_ACC: start_acc_reg <= cfg_data;
                    REG_END_POS:   end_pos_reg   <= cfg_data;
                    REG_END_VEL:   end_vel_reg   <= cfg_data;
                    REG_END_ACC:   end_acc_reg   <= cfg_data;
                    REG_DURATION:  duration_reg  <= cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end else if (busy) begin
                wait_cnt_reg <= wait_cnt_reg - CW'(1);
            end
        end
    end

    acc_t xs, vs, as, xe, ve, ae, vsr, asr;
    assign xs  = scale_in(start_pos_reg);
    assign vs  = scale_in(start_vel_reg);
    assign as  = scale_in(start_acc_reg);
    assign xe  = scale_in(end_pos_reg);
    assign ve  = scale_in(end_vel_reg);
    assign ae  = scale_in(end_acc_reg);
    assign vsr = raw_in(start_vel_reg);
    assign asr = raw_in(start_acc_reg);

    // ---------------- coefficient unit ----------------
    acc_t vt_c, at_c, at2_c, dvt_c, dat_c, dat2_c;
    logic vt_ov, at_ov, at2_ov, dvt_ov, dat_ov, dat2_ov;
    acc_t h_reg, dv_reg, da_reg;
    logic hd_ov_reg;
    acc_t d3_reg, d4_reg, d5_reg;
    logic d_ov_reg;
    acc_t d5x5_reg, d4x4_reg, d3x3_reg, d5x20_reg, d4x12_reg, d3x6_reg;
    acc_t d5x60_reg, d4x24_reg;
    logic k_ov_reg;
    logic coef_ov;

    qte_mulq u_vt (.aclk(aclk), .en(1'b1), .a(vsr), .b(t_dur), .c('0), .sh(SH_SV),
                   .ov_in(1'b0), .p(vt_c), .ov_out(vt_ov));
    qte_mulq u_at (.aclk(aclk), .en(1'b1), .a(asr), .b(t_dur), .c('0), .sh(SH_SV),
                   .ov_in(1'b0), .p(at_c), .ov_out(at_ov));
    qte_mulq u_at2 (.aclk(aclk), .en(1'b1), .a(at_c), .b(t_dur), .c('0), .sh(SH_F1),
                    .ov_in(1'b0), .p(at2_c), .ov_out(at2_ov));
    qte_mulq u_dvt (.aclk(aclk), .en(1'b1), .a(dv_reg), .b(t_dur), .c('0), .sh(SH_F),
                    .ov_in(1'b0), .p(dvt_c), .ov_out(dvt_ov));
    qte_mulq u_dat (.aclk(aclk), .en(1'b1), .a(da_reg), .b(t_dur), .c('0), .sh(SH_F),
                    .ov_in(1'b0), .p(dat_c), .ov_out(dat_ov));
    qte_mulq u_dat2 (.aclk(aclk), .en(1'b1), .a(dat_c), .b(t_dur), .c('0), .sh(SH_F),
                     .ov_in(1'b0), .p(dat2_c), .ov_out(dat2_ov));

    sat_t h1, h2, h3, v1, v2, a1;
    sat_t e3a, e3b, e3s, e3, e4a, e4b, e4c, e4d, e4, e5a, e5b, e5s, e5;
    sat_t k5, k4, k3, k20, k12, k6, k60, k24;

    always_comb begin
        h1 = sadd(xe, -xs);
        h2 = sadd(h1.val, -vt_c);
        h3 = sadd(h2.val, -at2_c);
        v1 = sadd(ve, -vs);
        v2 = sadd(v1.val, -at_c);
        a1 = sadd(ae, -as);

        e3a = mulk(h_reg, 8'sd20);
        e3b = mulk(dvt_c, -8'sd8);
        e3s = sadd(e3a.val, e3b.val);
        e3  = sadd(e3s.val, dat2_c);
        e4a = mulk(h_reg, -8'sd30);
        e4b = mulk(dvt_c, 8'sd14);
        e4c = mulk(dat2_c, -8'sd2);
        e4d = sadd(e4a.val, e4b.val);
        e4  = sadd(e4d.val, e4c.val);
        e5a = mulk(h_reg, 8'sd12);
        e5b = mulk(dvt_c, -8'sd6);
        e5s = sadd(e5a.val, e5b.val);
        e5  = sadd(e5s.val, dat2_c);

        k5  = mulk(d5_reg, 8'sd5);
        k4  = mulk(d4_reg, 8'sd4);
        k3  = mulk(d3_reg, 8'sd3);
        k20 = mulk(d5_reg, 8'sd20);
        k12 = mulk(d4_reg, 8'sd12);
        k6  = mulk(d3_reg, 8'sd6);
        k60 = mulk(d5_reg, 8'sd60);
        k24 = mulk(d4_reg, 8'sd24);
    end

    always_ff @(posedge aclk) begin
        h_reg     <= h3.val;
        dv_reg    <= v2.val;
        da_reg    <= a1.val;
        hd_ov_reg <= h1.ov | h2.ov | h3.ov | v1.ov | v2.ov | a1.ov;

        d3_reg    <= e3.val;
        d4_reg    <= e4.val;
        d5_reg    <= e5.val;
        d_ov_reg  <= e3a.ov | e3b.ov | e3s.ov | e3.ov
                   | e4a.ov | e4b.ov | e4c.ov | e4d.ov | e4.ov
                   | e5a.ov | e5b.ov | e5s.ov | e5.ov;

        d5x5_reg  <= k5.val;
        d4x4_reg  <= k4.val;
        d3x3_reg  <= k3.val;
        d5x20_reg <= k20.val;
        d4x12_reg <= k12.val;
        d3x6_reg  <= k6.val;
        d5x60_reg <= k60.val;
        d4x24_reg <= k24.val;
        k_ov_reg  <= k5.ov | k4.ov | k3.ov | k20.ov | k12.ov | k6.ov | k60.ov | k24.ov;
    end

    assign coef_ov = vt_ov | at_ov | at2_ov | dvt_ov | dat_ov | dat2_ov
                   | hd_ov_reg | d_ov_reg | k_ov_reg;

    // ---------------- sample pipeline ----------------
    logic              m_tvalid_reg;
    logic [4*VAL_W-1:0] m_tdata_reg;
    logic              m_tuser_reg;
    logic              vld_reg [0:T_END];
    logic [TIME_W-1:0] t_reg   [0:T_PB-MUL_LAT];
    acc_t              u_reg   [T_U+1:T_S4];

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && !busy;

    acc_t t0_w, t4_w;
    assign t0_w = acc_t'(t_reg[0]);
    assign t4_w = acc_t'(t_reg[T_PB-MUL_LAT]);

    acc_t u0, p1, att, vb, pb;
    logic u_ov, p1_ov, att_ov, vb_ov, pb_ov;

    qte_divt u_du (.aclk(aclk), .en(en), .x(t0_w), .sh(SH_U), .td(td), .ov_in(1'b0),
                   .y(u0), .ov_out(u_ov));
    qte_mulq u_p1 (.aclk(aclk), .en(en), .a(vsr), .b(t0_w), .c(xs), .sh(SH_SV),
                   .ov_in(1'b0), .p(p1), .ov_out(p1_ov));
    qte_mulq u_att (.aclk(aclk), .en(en), .a(asr), .b(t0_w), .c('0), .sh(SH_SV),
                    .ov_in(1'b0), .p(att), .ov_out(att_ov));
    qte_mulq u_vb (.aclk(aclk), .en(en), .a(asr), .b(t0_w), .c(vs), .sh(SH_SV),
                   .ov_in(1'b0), .p(vb), .ov_out(vb_ov));
    qte_mulq u_pb (.aclk(aclk), .en(en), .a(att), .b(t4_w), .c(p1), .sh(SH_F1),
                   .ov_in(p1_ov | att_ov), .p(pb), .ov_out(pb_ov));

    sat_t pb_reg  [T_PB+1:T_S4];
    sat_t vb_reg  [T_VB+1:T_VEL];
    sat_t pos_reg [T_POS+1:T_END];
    sat_t vel_reg [T_VEL+1:T_END];
    sat_t acc_reg [T_ACC+1:T_END];

    // position: Horner over d5, d4, d3 then three more powers of u
    acc_t q1, q2, q3, q4, q5;
    logic q1_ov, q2_ov, q3_ov, q4_ov, q5_ov;
    qte_mulq u_q1 (.aclk(aclk), .en(en), .a(d5_reg), .b(u0), .c(d4_reg), .sh(SH_U),
                   .ov_in(u_ov), .p(q1), .ov_out(q1_ov));
    qte_mulq u_q2 (.aclk(aclk), .en(en), .a(q1), .b(u_reg[T_S1]), .c(d3_reg), .sh(SH_U),
                   .ov_in(q1_ov), .p(q2), .ov_out(q2_ov));
    qte_mulq u_q3 (.aclk(aclk), .en(en), .a(q2), .b(u_reg[T_S2]), .c('0), .sh(SH_U),
                   .ov_in(q2_ov), .p(q3), .ov_out(q3_ov));
    qte_mulq u_q4 (.aclk(aclk), .en(en), .a(q3), .b(u_reg[T_S3]), .c('0), .sh(SH_U),
                   .ov_in(q3_ov), .p(q4), .ov_out(q4_ov));
    qte_mulq u_q5 (.aclk(aclk), .en(en), .a(q4), .b(u_reg[T_S4]), .c(pb_reg[T_S4].val),
                   .sh(SH_U1), .ov_in(q4_ov | pb_reg[T_S4].ov), .p(q5), .ov_out(q5_ov));

    // velocity
    acc_t r1, r2, r3, r4, rd;
    logic r1_ov, r2_ov, r3_ov, r4_ov, rd_ov;
    qte_mulq u_r1 (.aclk(aclk), .en(en), .a(d5x5_reg), .b(u0), .c(d4x4_reg), .sh(SH_U),
                   .ov_in(u_ov), .p(r1), .ov_out(r1_ov));
    qte_mulq u_r2 (.aclk(aclk), .en(en), .a(r1), .b(u_reg[T_S1]), .c(d3x3_reg), .sh(SH_U),
                   .ov_in(r1_ov), .p(r2), .ov_out(r2_ov));
    qte_mulq u_r3 (.aclk(aclk), .en(en), .a(r2), .b(u_reg[T_S2]), .c('0), .sh(SH_U),
                   .ov_in(r2_ov), .p(r3), .ov_out(r3_ov));
    qte_mulq u_r4 (.aclk(aclk), .en(en), .a(r3), .b(u_reg[T_S3]), .c('0), .sh(SH_U),
                   .ov_in(r3_ov), .p(r4), .ov_out(r4_ov));
    qte_divt u_rd (.aclk(aclk), .en(en), .x(r4), .sh(SH_FM), .td(td), .ov_in(r4_ov),
                   .y(rd), .ov_out(rd_ov));

    // acceleration
    acc_t a1p, a2p, a3p, ad1, ad2;
    logic a1_ov, a2_ov, a3_ov, ad1_ov, ad2_ov;
    qte_mulq u_a1 (.aclk(aclk), .en(en), .a(d5x20_reg), .b(u0), .c(d4x12_reg), .sh(SH_U),
                   .ov_in(u_ov), .p(a1p), .ov_out(a1_ov));
    qte_mulq u_a2 (.aclk(aclk), .en(en), .a(a1p), .b(u_reg[T_S1]), .c(d3x6_reg), .sh(SH_U),
                   .ov_in(a1_ov), .p(a2p), .ov_out(a2_ov));
    qte_mulq u_a3 (.aclk(aclk), .en(en), .a(a2p), .b(u_reg[T_S2]), .c('0), .sh(SH_U),
                   .ov_in(a2_ov), .p(a3p), .ov_out(a3_ov));
    qte_divt u_ad1 (.aclk(aclk), .en(en), .x(a3p), .sh(SH_F), .td(td), .ov_in(a3_ov),
                    .y(ad1), .ov_out(ad1_ov));
    qte_divt u_ad2 (.aclk(aclk), .en(en), .x(ad1), .sh(SH_FM), .td(td), .ov_in(ad1_ov),
                    .y(ad2), .ov_out(ad2_ov));

    // jerk
    acc_t j1, j2, jd1, jd2, jd3;
    logic j1_ov, j2_ov, jd1_ov, jd2_ov, jd3_ov;
    qte_mulq u_j1 (.aclk(aclk), .en(en), .a(d5x60_reg), .b(u0), .c(d4x24_reg), .sh(SH_U),
                   .ov_in(u_ov), .p(j1), .ov_out(j1_ov));
    qte_mulq u_j2 (.aclk(aclk), .en(en), .a(j1), .b(u_reg[T_S1]), .c(d3x6_reg), .sh(SH_U),
                   .ov_in(j1_ov), .p(j2), .ov_out(j2_ov));
    qte_divt u_jd1 (.aclk(aclk), .en(en), .x(j2), .sh(SH_F), .td(td), .ov_in(j2_ov),
                    .y(jd1), .ov_out(jd1_ov));
    qte_divt u_jd2 (.aclk(aclk), .en(en), .x(jd1), .sh(SH_F), .td(td), .ov_in(jd1_ov),
                    .y(jd2), .ov_out(jd2_ov));
    qte_divt u_jd3 (.aclk(aclk), .en(en), .x(jd2), .sh(SH_FM), .td(td), .ov_in(jd2_ov),
                    .y(jd3), .ov_out(jd3_ov));

    sat_t vel_sum, acc_sum;
    nar_t n_pos, n_vel, n_acc, n_jrk;

    always_comb begin
        vel_sum = sadd(vb_reg[T_VEL].val, rd);
        acc_sum = sadd(as, ad2);
        n_pos   = narrow(pos_reg[T_END].val);
        n_vel   = narrow(vel_reg[T_END].val);
        n_acc   = narrow(acc_reg[T_END].val);
        n_jrk   = narrow(jd3);
    end

    // alignment lines, all held by the same stall
    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg[0] <= s_tdata;
            for (int k = 1; k <= T_PB - MUL_LAT; k++) t_reg[k] <= t_reg[k-1];

            u_reg[T_U+1] <= u0;
            for (int k = T_U + 2; k <= T_S4; k++) u_reg[k] <= u_reg[k-1];

            pb_reg[T_PB+1] <= '{val: pb, ov: pb_ov};
            for (int k = T_PB + 2; k <= T_S4; k++) pb_reg[k] <= pb_reg[k-1];

            vb_reg[T_VB+1] <= '{val: vb, ov: vb_ov};
            for (int k = T_VB + 2; k <= T_VEL; k++) vb_reg[k] <= vb_reg[k-1];

            pos_reg[T_POS+1] <= '{val: q5, ov: q5_ov};
            for (int k = T_POS + 2; k <= T_END; k++) pos_reg[k] <= pos_reg[k-1];

            vel_reg[T_VEL+1] <= '{val: vel_sum.val,
                                  ov: vel_sum.ov | rd_ov | vb_reg[T_VEL].ov};
            for (int k = T_VEL + 2; k <= T_END; k++) vel_reg[k] <= vel_reg[k-1];

            acc_reg[T_ACC+1] <= '{val: acc_sum.val, ov: acc_sum.ov | ad2_ov};
            for (int k = T_ACC + 2; k <= T_END; k++) acc_reg[k] <= acc_reg[k-1];

            m_tdata_reg <= {n_jrk.val, n_acc.val, n_vel.val, n_pos.val};
            m_tuser_reg <= coef_ov | pos_reg[T_END].ov | vel_reg[T_END].ov
                         | acc_reg[T_END].ov | jd3_ov
                         | n_pos.ov | n_vel.ov | n_acc.ov | n_jrk.ov;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= T_END; k++) vld_reg[k] <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid & s_tready;
            for (int k = 1; k <= T_END; k++) vld_reg[k] <= vld_reg[k-1];
            m_tvalid_reg <= vld_reg[T_END];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
